@@ design/mcc_pkg.sv @@
package mcc_pkg;

    localparam int MAX_AMOUNT    = 1024;
    localparam int MAX_COINS     = 6;
    localparam int NUM_COIN_REGS = 6;

    localparam int TGT_W   = 10;
    localparam int VAL_W   = 10;
    localparam int TOT_W   = 10;
    localparam int CCNT_W  = 3;
    localparam int IDX_W   = 3;
    localparam int CDATA_W = 10;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam int AMT_W   = $clog2(MAX_AMOUNT);
    localparam int CNT_W   = AMT_W + 1;
    localparam int DIFF_W  = (AMT_W > VAL_W) ? AMT_W : VAL_W;
    localparam int K_W     = $clog2(NUM_COIN_REGS + 1);
    localparam int KSEL_W  = $clog2(NUM_COIN_REGS);
    localparam int COIN_LIM = (MAX_COINS < NUM_COIN_REGS) ? MAX_COINS : NUM_COIN_REGS;

    localparam logic [CNT_W-1:0] INF_MARK = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX  = {TOT_W{1'b1}};

    localparam logic [IDX_W-1:0] REG_COIN_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_COIN_VAL0  = 3'd1;
    localparam logic [IDX_W-1:0] REG_COIN_VAL5  = 3'd6;

    localparam logic [CCNT_W-1:0] RST_COIN_COUNT = 3'd3;

    typedef logic [NUM_COIN_REGS-1:0][VAL_W-1:0] t_coins;

    localparam t_coins RST_COINS = {10'd1, 10'd1, 10'd1, 10'd10, 10'd7, 10'd1};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [AMT_W-1:0] rd_addr;
        logic             wr_en;
        logic [AMT_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } t_mem_req;

endpackage

@@ design/mcc_cfg.sv @@
module mcc_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [mcc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mcc_pkg::CDATA_W-1:0] i_cfg_data,
    output mcc_pkg::t_coins         o_coins,
    output logic [mcc_pkg::K_W-1:0] o_ncoins
);
    import mcc_pkg::*;

    logic [CCNT_W-1:0] r_count;
    t_coins            r_coins;
    logic [IDX_W-1:0]  w_sel;

    assign w_sel = i_cfg_idx - REG_COIN_VAL0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RST_COIN_COUNT;
            r_coins <= RST_COINS;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COIN_COUNT) begin
                r_count <= i_cfg_data[CCNT_W-1:0];
            end else if (i_cfg_idx >= REG_COIN_VAL0 && i_cfg_idx <= REG_COIN_VAL5) begin
                r_coins[w_sel[KSEL_W-1:0]] <= i_cfg_data[VAL_W-1:0];
            end
        end
    end

    // saturate to the number of denominations the datapath walks
    always_comb begin
        if (32'(r_count) > COIN_LIM) begin
            o_ncoins = K_W'(COIN_LIM);
        end else begin
            o_ncoins = K_W'(r_count);
        end
    end

    assign o_coins = r_coins;

endmodule

@@ design/mcc_table.sv @@
module mcc_table (
    input  logic                      i_clk,
    input  mcc_pkg::t_mem_req         i_req,
    output logic [mcc_pkg::CNT_W-1:0] o_rd_data
);
    import mcc_pkg::*;

    logic [CNT_W-1:0] r_mem [MAX_AMOUNT];
    logic [CNT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/mcc_alu.sv @@
module mcc_alu (
    input  logic [mcc_pkg::AMT_W-1:0] i_amt,
    input  logic [mcc_pkg::VAL_W-1:0] i_coin,
    input  logic                      i_pend,
    input  logic [mcc_pkg::CNT_W-1:0] i_rd_data,
    input  logic [mcc_pkg::CNT_W-1:0] i_best,
    output logic                      o_hit,
    output logic [mcc_pkg::AMT_W-1:0] o_addr,
    output logic [mcc_pkg::CNT_W-1:0] o_best
);
    import mcc_pkg::*;

    logic [DIFF_W-1:0] w_amt;
    logic [DIFF_W-1:0] w_coin;
    logic [DIFF_W-1:0] w_diff;
    logic [CNT_W-1:0]  w_cand;

    assign w_amt  = DIFF_W'(i_amt);
    assign w_coin = DIFF_W'(i_coin);
    assign w_diff = w_amt - w_coin;
    assign o_hit  = (i_coin != '0) && (w_coin <= w_amt);
    assign o_addr = AMT_W'(w_diff);
    assign w_cand = i_rd_data + CNT_W'(1);

    always_comb begin
        o_best = i_best;
        if (i_pend && i_rd_data != INF_MARK && w_cand < i_best) begin
            o_best = w_cand;
        end
    end

endmodule

@@ design/mcc_seq.sv @@
module mcc_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mcc_pkg::TGT_W-1:0]     i_target,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mcc_pkg::TOT_W-1:0]     o_total,
    output logic                          o_unreach,
    input  mcc_pkg::t_coins               i_coins,
    input  logic [mcc_pkg::K_W-1:0]       i_ncoins,
    output mcc_pkg::t_mem_req             o_req,
    input  logic [mcc_pkg::CNT_W-1:0]     i_rd_data
);
    import mcc_pkg::*;

    t_state            r_state, n_state;
    logic [AMT_W-1:0]  r_amt, n_amt;
    logic [AMT_W-1:0]  r_target, n_target;
    logic [K_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]  r_best, n_best;
    logic              r_pend, n_pend;
    logic              r_m_valid, n_m_valid;
    logic [TOT_W-1:0]  r_m_total, n_m_total;
    logic              r_m_unr, n_m_unr;

    logic              w_acc;
    logic              w_oor;
    logic              w_zero;
    logic              w_last_k;
    logic              w_last_amt;
    logic              w_load;
    logic [KSEL_W-1:0] w_ksel;
    logic              w_hit;
    logic [AMT_W-1:0]  w_addr;
    logic [CNT_W-1:0]  w_best_nx;

    assign w_acc      = i_s_tvalid && (r_state == ST_IDLE);
    assign w_oor      = 32'(i_target) >= MAX_AMOUNT;
    assign w_zero     = (i_target == '0);
    assign w_last_k   = (r_k >= i_ncoins);
    assign w_last_amt = (r_amt == r_target);
    assign w_load     = !r_m_valid || i_m_tready;
    assign w_ksel     = (32'(r_k) < NUM_COIN_REGS) ? r_k[KSEL_W-1:0] : '0;

    mcc_alu u_alu (
        .i_amt     (r_amt),
        .i_coin    (i_coins[w_ksel]),
        .i_pend    (r_pend),
        .i_rd_data (i_rd_data),
        .i_best    (r_best),
        .o_hit     (w_hit),
        .o_addr    (w_addr),
        .o_best    (w_best_nx)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = (w_oor || w_zero) ? ST_FIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_last_k && w_last_amt) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_amt     = r_amt;
        n_target  = r_target;
        n_k       = r_k;
        n_best    = r_best;
        n_pend    = 1'b0;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_total = r_m_total;
        n_m_unr   = r_m_unr;
        o_req     = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_target = AMT_W'(i_target);
                    n_amt    = AMT_W'(1);
                    n_k      = '0;
                    n_best   = (w_zero && !w_oor) ? '0 : INF_MARK;
                    // seed entry zero
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = '0;
                    o_req.wr_data = '0;
                end
            end
            ST_ISSUE: begin
                n_best = w_best_nx;
                if (!w_last_k) begin
                    o_req.rd_en   = w_hit;
                    o_req.rd_addr = w_addr;
                    n_pend        = w_hit;
                    n_k           = r_k + K_W'(1);
                end else begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_amt;
                    o_req.wr_data = w_best_nx;
                    n_k           = '0;
                    n_amt         = r_amt + AMT_W'(1);
                    if (!w_last_amt) begin
                        n_best = INF_MARK;
                    end
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_m_valid = 1'b1;
                    if (r_best == INF_MARK) begin
                        n_m_unr   = 1'b1;
                        n_m_total = '0;
                    end else begin
                        n_m_unr   = 1'b0;
                        n_m_total = (32'(r_best) > 32'(TOT_MAX)) ? TOT_MAX : TOT_W'(r_best);
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt     <= n_amt;
        r_target  <= n_target;
        r_k       <= n_k;
        r_best    <= n_best;
        r_m_total <= n_m_total;
        r_m_unr   <= n_m_unr;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_total    = r_m_total;
    assign o_unreach  = r_m_unr;

endmodule

@@ design/min_coin_change.sv @@
// Fewest-coins solver. Each input transaction carries a target amount; the block
// fills a scratch table bottom-up from 1 to the target, with at most one table
// read per enabled coin per amount through the table's read port and a single
// subtract/compare unit, plus one write-back per amount. A target of zero or one
// beyond the table skips the fill and goes straight to the finish state. The
// input is not ready while an item is at work; a finished result sits in an
// output register, so the next target is taken while it waits. Coin registers
// must be written only while idle; the block itself does not enforce this.
// tuser flags an unreachable amount, in which case the coin count reads zero.
module min_coin_change (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // [9:0] target_amount, [15:10] zero
    input  logic [mcc_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [9:0] coin_total, [15:10] zero
    output logic [mcc_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [0] unreachable
    output logic                             o_m_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic                             i_cfg_we,
    input  logic [mcc_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [mcc_pkg::CDATA_W-1:0]      i_cfg_data
);
    import mcc_pkg::*;

    t_coins           w_coins;
    logic [K_W-1:0]   w_ncoins;
    t_mem_req         w_req;
    logic [CNT_W-1:0] w_rd_data;
    logic [TOT_W-1:0] w_total;

    mcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coins    (w_coins),
        .o_ncoins   (w_ncoins)
    );

    mcc_table u_table (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    mcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_target   (i_s_tdata[TGT_W-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_total    (w_total),
        .o_unreach  (o_m_tuser),
        .i_coins    (w_coins),
        .i_ncoins   (w_ncoins),
        .o_req      (w_req),
        .i_rd_data  (w_rd_data)
    );

    assign o_m_tdata = M_TDATA_W'(w_total);

endmodule

@@ design/mcc_checker.sv @@
module mcc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [mcc_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic                          o_m_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready
);
    import mcc_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("unreachable result with nonzero count");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready again straight after a transaction");

endmodule

bind min_coin_change mcc_checker u_mcc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mcc_pkg::*;

    localparam int          LIMIT_CYCLES = 4_000_000;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          N_DIR_ROWS   = 33;
    localparam int          SEG_ITEMS    = 10;
    localparam int unsigned NO_PATH      = 32'hFFFF_FFFF;

    localparam logic [IDX_W-1:0] REG_COIN_VAL1 = REG_COIN_VAL0 + 3'd1;
    localparam logic [IDX_W-1:0] REG_COIN_VAL2 = REG_COIN_VAL0 + 3'd2;
    localparam logic [IDX_W-1:0] REG_COIN_VAL3 = REG_COIN_VAL0 + 3'd3;
    localparam logic [IDX_W-1:0] REG_COIN_VAL4 = REG_COIN_VAL0 + 3'd4;
    localparam logic [IDX_W-1:0] REG_UNUSED    = REG_COIN_VAL5 + 3'd1;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_CHECK
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [IDX_W-1:0]    idx;
        logic [CDATA_W-1:0]  data;
        logic [TGT_W-1:0]    amount;
        logic [TOT_W-1:0]    exp_total;
        logic                exp_unreachable;
    } t_stim_row;

    typedef struct {
        logic [TOT_W-1:0] total;
        logic             unreachable;
    } t_coin_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [IDX_W-1:0]      i_cfg_idx  = '0;
    logic [CDATA_W-1:0]    i_cfg_data = '0;

    logic [CCNT_W-1:0] sh_count = 3'd3;
    logic [VAL_W-1:0]  sh_coin [NUM_COIN_REGS] = '{10'd1, 10'd7, 10'd10, 10'd1, 10'd1, 10'd1};
    int unsigned       coin_table [MAX_AMOUNT];

    t_coin_result pending_results [$];
    t_stim_row    dir_rows [N_DIR_ROWS];
    int           mismatches     = 0;
    int           send_idle_pct  = 0;
    int           ready_idle_pct = 0;
    int           hold_req       = 0;
    int           hold_seen      = 0;
    int           hold_left      = 0;
    int unsigned  cycle_count    = 0;

    min_coin_change u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_coin_result predict_min_coins(input logic [TGT_W-1:0] amount);
        t_coin_result res;
        int           active;
        int unsigned  best;
        int unsigned  v;
        active = int'(sh_count);
        if (active > COIN_LIM) active = COIN_LIM;
        res.total = '0;
        res.unreachable = 1'b1;
        if (int'(amount) >= MAX_AMOUNT) return res;
        coin_table[0] = 0;
        for (int amt = 1; amt <= int'(amount); amt++) begin
            best = NO_PATH;
            for (int k = 0; k < active; k++) begin
                v = sh_coin[k];
                if (v != 0 && v <= amt && coin_table[amt - v] != NO_PATH
                        && coin_table[amt - v] + 1 < best) begin
                    best = coin_table[amt - v] + 1;
                end
            end
            coin_table[amt] = best;
        end
        best = coin_table[amount];
        if (best != NO_PATH) begin
            res.total = (best > TOT_MAX) ? TOT_MAX : best[TOT_W-1:0];
            res.unreachable = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [TGT_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return TGT_W'($urandom_range(0, 40));
        if (r < 85) return TGT_W'($urandom_range(0, 255));
        if (r < 97) return TGT_W'($urandom);
        return {TGT_W{1'b1}};
    endfunction

    function automatic logic [VAL_W-1:0] pick_coin();
        if ($urandom_range(0, 99) < 80) return VAL_W'($urandom_range(1, 24));
        return VAL_W'($urandom_range(1, 1023));
    endfunction

    task automatic offer_target(input logic [TGT_W-1:0] amount, input bit typed,
                                input logic [TOT_W-1:0] exp_total, input logic exp_unr);
        t_coin_result want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-TGT_W){1'b0}}, amount};
        do @(posedge i_clk); while (!o_s_tready);
        if (typed) begin
            want.total = exp_total;
            want.unreachable = exp_unr;
        end else begin
            want = predict_min_coins(amount);
        end
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_COIN_COUNT) begin
            sh_count = data[CCNT_W-1:0];
        end else if (idx >= REG_COIN_VAL0 && idx <= REG_COIN_VAL5) begin
            sh_coin[idx - REG_COIN_VAL0] = data[VAL_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // drop valid and wait for the block to go idle
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_coin_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction: coin_total %0d unreachable %0b",
                       o_m_tdata[TOT_W-1:0], o_m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[TOT_W-1:0] !== want.total) begin
                    $error("coin_total: expected %0d, actual %0d",
                           want.total, o_m_tdata[TOT_W-1:0]);
                    mismatches++;
                end
                if (o_m_tuser !== want.unreachable) begin
                    $error("unreachable: expected %0b, actual %0b",
                           want.unreachable, o_m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("min_coin_change verification failed");
        $finish;
    end

    initial begin
        logic [CDATA_W-1:0] cnt_data;
        logic [VAL_W-1:0]   vals [NUM_COIN_REGS];
        t_stim_row          row;

        dir_rows = '{
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd1,    10'd1,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd7,    10'd1,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd10,   10'd1,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd14,   10'd2,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd512,  10'd0,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd341,  10'd0,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd682,  10'd0,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd1023, 10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_COUNT, 10'd1,    10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL0,  10'd1,    10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd1023, 10'd1023, 1'b0},
            '{ROW_CFG,   REG_COIN_COUNT, 10'd0,    10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd5,    10'd0,    1'b1},
            '{ROW_CFG,   REG_COIN_COUNT, 10'd1023, 10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL0,  10'd0,    10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL1,  10'd3,    10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL2,  10'd5,    10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL3,  10'd1023, 10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL4,  10'd1023, 10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL5,  10'd1023, 10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd1023, 10'd1,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd1,    10'd0,    1'b1},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd7,    10'd0,    1'b1},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd8,    10'd2,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd1022, 10'd0,    1'b0},
            '{ROW_CFG,   REG_UNUSED,     10'd1,    10'd0,    10'd0,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd100,  10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_COUNT, 10'd2,    10'd0,    10'd0,    1'b0},
            '{ROW_CFG,   REG_COIN_VAL0,  10'd1023, 10'd0,    10'd0,    1'b0},
            '{ROW_CHECK, REG_COIN_COUNT, 10'd0,    10'd9,    10'd3,    1'b0},
            '{ROW_ITEM,  REG_COIN_COUNT, 10'd0,    10'd1021, 10'd0,    1'b0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct  = 31;
        ready_idle_pct = 85;
        for (int r = 0; r < N_DIR_ROWS; r++) begin
            row = dir_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    cfg_write(row.idx, row.data);
                end
                ROW_ITEM: begin
                    offer_target(row.amount, 1'b0, '0, 1'b0);
                end
                default: begin
                    offer_target(row.amount, 1'b1, row.exp_total, row.exp_unreachable);
                end
            endcase
        end

        for (int seg = 0; seg < 8; seg++) begin
            settle();
            if (seg < 3) begin
                send_idle_pct  = 31;
                ready_idle_pct = 85;
            end else if (seg < 6) begin
                send_idle_pct  = 85;
                ready_idle_pct = 31;
            end else begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end
            for (int k = 0; k < NUM_COIN_REGS; k++) vals[k] = pick_coin();
            case (seg)
                0: cnt_data = 10'd3;
                1: begin
                    cnt_data = 10'd6;
                    for (int k = 0; k < NUM_COIN_REGS; k++) vals[k] = {VAL_W{1'b1}};
                end
                2: cnt_data = 10'd6;
                3: begin
                    cnt_data = {7'($urandom_range(0, 127)), 3'd7};
                    vals[$urandom_range(0, NUM_COIN_REGS - 1)] = '0;
                end
                4: cnt_data = 10'd0;
                5: cnt_data = 10'd1;
                6: cnt_data = 10'd6;
                default: cnt_data = 10'($urandom_range(1, 6));
            endcase
            cfg_write(REG_COIN_COUNT, cnt_data);
            for (int k = 0; k < NUM_COIN_REGS; k++) begin
                cfg_write(REG_COIN_VAL0 + IDX_W'(k), vals[k]);
            end
            if (seg == 0) cfg_write(REG_UNUSED, CDATA_W'($urandom));
            // stall the output long enough to back up the input
            if (seg == 6) hold_req++;
            for (int n = 0; n < SEG_ITEMS; n++) begin
                offer_target((seg == 6) ? TGT_W'($urandom_range(0, 40)) : pick_target(),
                             1'b0, '0, 1'b0);
            end
        end

        settle();
        repeat (32) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("min_coin_change verification clean");
        end else begin
            $display("min_coin_change verification failed");
        end
        $finish;
    end

endmodule
